// File: rtl/fat12ta_pkg.sv
package fat12ta_pkg;

   localparam int ENTRY_W    = 12;
   localparam int LIMIT_W    = 13;
   localparam int ROW_BITS   = 24;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

   localparam logic [ENTRY_W-1:0]  END_MARK   = 12'hFFF;
   localparam logic [ENTRY_W-1:0]  FREE_ENTRY = 12'h000;
   // Row 0 holds the media byte F0 and the reserved entry FFF.
   localparam logic [ROW_BITS-1:0] ROW0_INIT  = 24'hFFFFF0;

   typedef logic [ENTRY_W-1:0]  entry_type;
   typedef logic [ROW_BITS-1:0] row_type;

   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic rw_read;
      logic rw_exec;
      logic al_init;
      logic al_load;
      logic al_found;
      logic al_skip;
      logic al_end;
      logic set_full;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             clr_last;
      logic [CMD_W-1:0] cmd;
      logic             in_range;
      logic             count_zero;
      logic             past_limit;
      logic             entry_free;
      logic             last_link;
      logic             idx_odd;
   } dp_status_type;

   function automatic entry_type get_half(input row_type row, input logic odd);
      get_half = odd ? row[2*ENTRY_W-1:ENTRY_W] : row[ENTRY_W-1:0];
   endfunction

   function automatic row_type set_half(input row_type row, input logic odd,
                                        input entry_type v);
      row_type r;
      r = row;
      if (odd) begin
         r[2*ENTRY_W-1:ENTRY_W] = v;
      end else begin
         r[ENTRY_W-1:0] = v;
      end
      set_half = r;
   endfunction

endpackage

// File: rtl/fat12ta_ctrl.sv
module fat12ta_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  fat12ta_pkg::dp_status_type st,
   output fat12ta_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_RW_EX    = 4'd3;
   localparam logic [3:0] S_AL_RD    = 4'd4;
   localparam logic [3:0] S_AL_LD    = 4'd5;
   localparam logic [3:0] S_AL_SC    = 4'd6;
   localparam logic [3:0] S_AL_END   = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.cmd)
               fat12ta_pkg::CMD_READ, fat12ta_pkg::CMD_WRITE: begin
                  if (st.in_range) begin
                     cmd.rw_read = 1'b1;
                     state_in    = S_RW_EX;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               fat12ta_pkg::CMD_ALLOC: begin
                  if (st.count_zero) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.al_init = 1'b1;
                     state_in    = S_AL_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RW_EX: begin
            cmd.rw_exec = 1'b1;
            state_in    = S_DONE;
         end
         S_AL_RD: begin
            state_in = S_AL_LD;
         end
         S_AL_LD: begin
            cmd.al_load = 1'b1;
            state_in    = S_AL_SC;
         end
         S_AL_SC: begin
            priority if (st.past_limit) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else if (st.entry_free) begin
               cmd.al_found = 1'b1;
               if (st.last_link) begin
                  state_in = S_AL_END;
               end else if (st.idx_odd) begin
                  state_in = S_AL_RD;
               end
            end else begin
               cmd.al_skip = 1'b1;
               if (st.idx_odd) begin
                  state_in = S_AL_RD;
               end
            end
         end
         S_AL_END: begin
            cmd.al_end = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/fat12ta_datapath.sv
module fat12ta_datapath #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [fat12ta_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [fat12ta_pkg::CMD_W-1:0]            req_tuser,
   output logic [fat12ta_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                     csr_valid,
   input  logic [fat12ta_pkg::LIMIT_W-1:0]          csr_data,
   input  fat12ta_pkg::ctrl_cmd_type                cmd,
   output fat12ta_pkg::dp_status_type               st
);

   localparam int ROWS  = TABLE_ENTRIES / 2;
   localparam int ROW_W = $clog2(ROWS);
   localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [fat12ta_pkg::LIMIT_W-1:0] MAX_L = fat12ta_pkg::LIMIT_W'(TABLE_ENTRIES);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   fat12ta_pkg::row_type row_mem [ROWS];
   fat12ta_pkg::row_type rd_data_ff;
   logic [ROW_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   fat12ta_pkg::row_type wr_data;

   logic [fat12ta_pkg::CMD_W-1:0]   req_cmd_ff;
   fat12ta_pkg::entry_type          req_cluster_ff, req_value_ff, req_count_ff;
   logic [IDX_W-1:0]                idx_ff, idx_in, prev_ff, prev_in;
   logic                            have_prev_ff, have_prev_in;
   fat12ta_pkg::entry_type          first_ff, first_in, remaining_ff, remaining_in;
   fat12ta_pkg::row_type            row_buf_ff, row_buf_in, prev_row_ff, prev_row_in;
   fat12ta_pkg::entry_type          res_read_ff, res_read_in, res_start_ff, res_start_in;
   logic                            res_full_ff, res_full_in;
   logic [fat12ta_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [ROW_W-1:0]                clr_ff, clr_in;
   logic [fat12ta_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   fat12ta_pkg::entry_type idx_entry;
   logic                   same_row;
   fat12ta_pkg::row_type   linked_prev;

   assign idx_entry   = fat12ta_pkg::ENTRY_W'(idx_ff);
   assign same_row    = (prev_ff[ROW_W:1] == idx_ff[ROW_W:1]);
   assign linked_prev = fat12ta_pkg::set_half(prev_row_ff, prev_ff[0], idx_entry);

   // Table memory: one write port, one registered read port.
   assign rd_addr = cmd.rw_read ? req_cluster_ff[ROW_W:1] : idx_ff[ROW_W:1];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      priority if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_data = (clr_ff == '0) ? fat12ta_pkg::ROW0_INIT : '0;
      end else if (cmd.rw_exec && req_cmd_ff == fat12ta_pkg::CMD_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = req_cluster_ff[ROW_W:1];
         wr_data = fat12ta_pkg::set_half(rd_data_ff, req_cluster_ff[0], req_value_ff);
      end else if (cmd.al_found && have_prev_ff) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff[ROW_W:1];
         wr_data = linked_prev;
      end else if (cmd.al_end) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff[ROW_W:1];
         wr_data = fat12ta_pkg::set_half(prev_row_ff, prev_ff[0], fat12ta_pkg::END_MARK);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= row_mem[rd_addr];
   end

   always_comb begin
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      first_in     = first_ff;
      remaining_in = remaining_ff;
      row_buf_in   = row_buf_ff;
      prev_row_in  = prev_row_ff;
      res_read_in  = res_read_ff;
      res_start_in = res_start_ff;
      res_full_in  = res_full_ff;
      if (cmd.load_req) begin
         res_read_in  = '0;
         res_start_in = '0;
         res_full_in  = 1'b0;
      end
      if (cmd.rw_exec && req_cmd_ff == fat12ta_pkg::CMD_READ) begin
         res_read_in = fat12ta_pkg::get_half(rd_data_ff, req_cluster_ff[0]);
      end
      if (cmd.al_init) begin
         idx_in       = '0;
         have_prev_in = 1'b0;
         remaining_in = req_count_ff;
      end
      if (cmd.al_load) begin
         row_buf_in = rd_data_ff;
      end
      if (cmd.al_skip) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.al_found) begin
         idx_in       = idx_ff + 1'b1;
         prev_in      = idx_ff;
         have_prev_in = 1'b1;
         remaining_in = remaining_ff - 1'b1;
         if (!have_prev_ff) begin
            first_in = idx_entry;
         end
         // The link lands in the scanned row when both entries share it.
         if (have_prev_ff && same_row) begin
            row_buf_in  = fat12ta_pkg::set_half(row_buf_ff, prev_ff[0], idx_entry);
            prev_row_in = row_buf_in;
         end else begin
            prev_row_in = row_buf_ff;
         end
      end
      if (cmd.al_end) begin
         res_start_in = first_ff;
      end
      if (cmd.set_full) begin
         res_full_in = 1'b1;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      limit_in = limit_ff;
      if (csr_valid) begin
         limit_in = (csr_data > MAX_L) ? MAX_L : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         limit_ff <= MAX_L;
      end else begin
         clr_ff   <= clr_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_cmd_ff     <= req_tuser;
         req_cluster_ff <= req_tdata[11:0];
         req_value_ff   <= req_tdata[23:12];
         req_count_ff   <= req_tdata[35:24];
      end
      if (cmd.publish) begin
         rsp_data_ff <= {7'd0, res_full_ff, res_start_ff, res_read_ff};
      end
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      first_ff     <= first_in;
      remaining_ff <= remaining_in;
      row_buf_ff   <= row_buf_in;
      prev_row_ff  <= prev_row_in;
      res_read_ff  <= res_read_in;
      res_start_ff <= res_start_in;
      res_full_ff  <= res_full_in;
   end

   assign rsp_tdata = rsp_data_ff;

   assign st.clr_last   = (clr_ff == LAST_ROW);
   assign st.cmd        = req_cmd_ff;
   assign st.in_range   = ({1'b0, req_cluster_ff} < MAX_L);
   assign st.count_zero = (req_count_ff == '0);
   assign st.past_limit = (fat12ta_pkg::LIMIT_W'(idx_ff) >= limit_ff);
   assign st.entry_free =
      (fat12ta_pkg::get_half(row_buf_ff, idx_ff[0]) == fat12ta_pkg::FREE_ENTRY);
   assign st.last_link  = (remaining_ff == fat12ta_pkg::ENTRY_W'(1));
   assign st.idx_odd    = idx_ff[0];

endmodule

// File: rtl/fat12_table_allocator.sv
// FAT12 allocation table with a first-fit chain allocator. The table holds
// TABLE_ENTRIES 12-bit entries packed two per 24-bit row in a single-port-write,
// registered-read memory. After reset a clearing pass writes every row (row 0
// gets bytes F0 FF FF, the rest zero); no request is taken during it. The limit
// register may be written during the clearing pass, and otherwise only while no
// request is in flight. One request is worked on at a time and gives exactly one
// response. A read or write goes from dispatch through an execute state to the
// done state, its row read-modify-write passing through the memory's registered
// read port; an index at or above TABLE_ENTRIES reads as zero and writes nothing.
// An index out of range, an allocate with a zero count and the unused command go
// from dispatch straight to the done state. An allocate with a nonzero count
// loads each row through a read state and a load state, checks one entry per
// cycle in its scan state, and writes the end mark in a state of its own when
// the chain completes. The done state hands the response to the output register,
// which waits while an earlier response is still held; the next request can be
// accepted from the cycle after that hand-over.
module fat12_table_allocator #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // cluster[11:0], value[23:12], count[35:24], zero pad
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_value[11:0], chain_head[23:12], status[24], pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data    // cluster_limit
);

   fat12ta_pkg::ctrl_cmd_type  cmd;
   fat12ta_pkg::dp_status_type st;

   fat12ta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fat12ta_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .st        (st)
   );

   assign csr_ready = 1'b1;

endmodule
